@@ hdl/rlic_pkg.sv @@
package rlic_pkg;

  localparam int MAX_LINES_DEF = 256;
  localparam int POS_W         = 32;
  localparam int HITS_W        = 11;
  localparam int TOTAL_W       = 48;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  typedef enum logic [1:0] {
    REQ_LOAD_H = 2'd0,
    REQ_LOAD_V = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_V,
    ST_SCAN_H,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    req_type_t                req_type;
    logic signed [POS_W-1:0]  line_pos;
    logic signed [POS_W-1:0]  corner1_x;
    logic signed [POS_W-1:0]  corner1_y;
    logic signed [POS_W-1:0]  corner2_x;
    logic signed [POS_W-1:0]  corner2_y;
  } in_item_t;

  typedef struct packed {
    logic [HITS_W-1:0]  rect_hits;
    logic [TOTAL_W-1:0] total_hits;
    logic               status;
  } out_item_t;

endpackage

@@ hdl/rlic_store.sv @@
module rlic_store #(
  parameter int DEPTH = rlic_pkg::MAX_LINES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic signed [rlic_pkg::POS_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic signed [rlic_pkg::POS_W-1:0] rd_data
);
  import rlic_pkg::*;

  logic signed [POS_W-1:0] mem [DEPTH];
  logic signed [POS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/rect_line_intersection_counter_core.sv @@
// rectangle / infinite line intersection counter
//
// input channel (in_valid, in_stall, in_data): one transfer per request.
// load requests append a line position to the horizontal or vertical store,
// a query gives two opposite rectangle corners, a clear empties both stores
// and the running total. every request gives exactly one result transfer on
// the output channel (out_valid, out_stall, out_data).
// loads and clears: the request goes from the idle state straight to the
// output state, which moves the result into the output register.
// queries: a single range compare unit walks the filled entries of the
// vertical store and then those of the horizontal store, one entry per cycle
// through the registered read port of each store.
// in_stall is high while a request is in work; the next request is taken
// as soon as the result sits in the output register, even if out_stall holds
// it there. a finished result waits inside the block until the output
// register is free.
// reset empties both stores and clears the running total; store contents
// need no clearing since only filled entries are ever read.
module rect_line_intersection_counter_core #(
  parameter int MAX_LINES = rlic_pkg::MAX_LINES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlic_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rlic_pkg::out_item_t out_data
);
  import rlic_pkg::*;

  localparam int AW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNTW = $clog2(MAX_LINES + 1);
  localparam int CW   = $clog2(2 * MAX_LINES + 1);
  localparam int HW   = CW + 1;
  localparam int SW   = TOTAL_W + 1;

  state_t                  state_r, state_nxt;
  logic [CNTW-1:0]         hcount_r, hcount_nxt;
  logic [CNTW-1:0]         vcount_r, vcount_nxt;
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    pend_r, pend_nxt;
  logic                    pend_h_r, pend_h_nxt;
  logic [CNTW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [POS_W-1:0] xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic signed [POS_W-1:0] ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [HITS_W-1:0]       res_hits_r, res_hits_nxt;
  logic                    res_status_r, res_status_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic                    h_wr, v_wr, h_rd, v_rd;
  logic signed [POS_W-1:0] h_rd_data, v_rd_data;
  logic signed [POS_W-1:0] cmp_data, cmp_lo, cmp_hi;
  logic                    cmp_hit;
  logic [HW-1:0]           hits;
  logic [SW-1:0]           hits_ext, sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign h_wr = in_xfer && (in_data.req_type == REQ_LOAD_H) &&
                (hcount_r < CNTW'(MAX_LINES));
  assign v_wr = in_xfer && (in_data.req_type == REQ_LOAD_V) &&
                (vcount_r < CNTW'(MAX_LINES));
  assign v_rd = (state_r == ST_SCAN_V) && (idx_r < vcount_r);
  assign h_rd = (state_r == ST_SCAN_H) && (idx_r < hcount_r);

  rlic_store #(.DEPTH(MAX_LINES), .AW(AW)) u_horiz (
    .clk     (clk),
    .wr_en   (h_wr),
    .wr_addr (hcount_r[AW-1:0]),
    .wr_data (in_data.line_pos),
    .rd_en   (h_rd),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (h_rd_data)
  );

  rlic_store #(.DEPTH(MAX_LINES), .AW(AW)) u_vert (
    .clk     (clk),
    .wr_en   (v_wr),
    .wr_addr (vcount_r[AW-1:0]),
    .wr_data (in_data.line_pos),
    .rd_en   (v_rd),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (v_rd_data)
  );

  // shared range compare
  assign cmp_data = pend_h_r ? h_rd_data : v_rd_data;
  assign cmp_lo   = pend_h_r ? ylo_r : xlo_r;
  assign cmp_hi   = pend_h_r ? yhi_r : xhi_r;
  assign cmp_hit  = pend_r && (cmp_data >= cmp_lo) && (cmp_data <= cmp_hi);

  assign hits     = {cnt_r, 1'b0};
  assign hits_ext = SW'(hits);
  assign sum      = {1'b0, total_r} + hits_ext;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_data.req_type == REQ_QUERY) ? ST_SCAN_V : ST_OUT;
        end
      end
      ST_SCAN_V: begin
        if (!v_rd) begin
          state_nxt = ST_SCAN_H;
        end
      end
      ST_SCAN_H: begin
        if (!h_rd) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    hcount_nxt     = hcount_r;
    vcount_nxt     = vcount_r;
    total_nxt      = total_r;
    pend_nxt       = 1'b0;
    pend_h_nxt     = pend_h_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r + CW'(cmp_hit);
    xlo_nxt        = xlo_r;
    xhi_nxt        = xhi_r;
    ylo_nxt        = ylo_r;
    yhi_nxt        = yhi_r;
    res_hits_nxt   = res_hits_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_hits_nxt   = '0;
          res_status_nxt = 1'b0;
          idx_nxt        = '0;
          cnt_nxt        = '0;
          unique case (in_data.req_type)
            REQ_LOAD_H: begin
              if (h_wr) begin
                hcount_nxt = hcount_r + 1'b1;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            REQ_LOAD_V: begin
              if (v_wr) begin
                vcount_nxt = vcount_r + 1'b1;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (in_data.corner1_x < in_data.corner2_x) begin
                xlo_nxt = in_data.corner1_x;
                xhi_nxt = in_data.corner2_x;
              end else begin
                xlo_nxt = in_data.corner2_x;
                xhi_nxt = in_data.corner1_x;
              end
              if (in_data.corner1_y < in_data.corner2_y) begin
                ylo_nxt = in_data.corner1_y;
                yhi_nxt = in_data.corner2_y;
              end else begin
                ylo_nxt = in_data.corner2_y;
                yhi_nxt = in_data.corner1_y;
              end
            end
            REQ_CLEAR: begin
              hcount_nxt = '0;
              vcount_nxt = '0;
              total_nxt  = '0;
            end
            default: begin
              res_status_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN_V: begin
        if (v_rd) begin
          pend_nxt   = 1'b1;
          pend_h_nxt = 1'b0;
          idx_nxt    = idx_r + 1'b1;
        end else begin
          idx_nxt = '0;
        end
      end
      ST_SCAN_H: begin
        if (h_rd) begin
          pend_nxt   = 1'b1;
          pend_h_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end
      end
      ST_SUM: begin
        total_nxt    = sum[SW-1] ? '1 : sum[TOTAL_W-1:0];
        res_hits_nxt = (hits_ext > SW'(HITS_MAX)) ? HITS_MAX : hits_ext[HITS_W-1:0];
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.rect_hits  = res_hits_r;
          out_data_nxt.total_hits = total_r;
          out_data_nxt.status     = res_status_r;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hcount_r    <= '0;
      vcount_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hcount_r    <= hcount_nxt;
      vcount_r    <= vcount_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_h_r     <= pend_h_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    xlo_r        <= xlo_nxt;
    xhi_r        <= xhi_nxt;
    ylo_r        <= ylo_nxt;
    yhi_r        <= yhi_nxt;
    res_hits_r   <= res_hits_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (hcount_r <= CNTW'(MAX_LINES)) && (vcount_r <= CNTW'(MAX_LINES)))
    else $error("store fill count beyond depth");

  a_scan_idx_v: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_V) |-> (idx_r <= vcount_r))
    else $error("vertical scan index past fill count");

  a_scan_idx_h: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_H) |-> (idx_r <= hcount_r))
    else $error("horizontal scan index past fill count");

  a_no_pend_at_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> !pend_r)
    else $error("compare still pending when total is updated");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result transfer raised outside output state");

endmodule
